/* rtl/obm_pkg.sv */
// Package of types and codes shared by the order book matcher cells and top level.
`default_nettype none
package obm_pkg;

	typedef struct packed {
		logic        order_side;
		logic        order_kind;
		logic [31:0] order_id;
		logic [31:0] limit_price;
		logic [31:0] order_quantity;
		logic [63:0] arrival_time;
	} order_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] buyer_id;
		logic [31:0] seller_id;
		logic [31:0] trade_price;
		logic [31:0] trade_quantity;
		logic [63:0] trade_time;
		logic [31:0] leftover_quantity;
		logic        did_rest;
		logic        book_full;
		logic        last_of_run;
	} result_t;

	// Search word handed from cell to cell: best entry so far and first free entry.
	typedef struct packed {
		logic        found;
		logic [31:0] price;
		logic [31:0] qty;
		logic [31:0] id;
		logic [31:0] age;
		logic        free_found;
	} token_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_REDUCE,
		CMD_LOAD
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [31:0] amount;
		logic [31:0] price;
		logic [31:0] id;
		logic [31:0] seq;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	localparam logic KIND_TRADE    = 1'b0;
	localparam logic KIND_COMPLETE = 1'b1;
	localparam logic SIDE_BUY      = 1'b0;
	localparam logic SIDE_SELL     = 1'b1;
	localparam logic ORDER_LIMIT   = 1'b0;
	localparam logic ORDER_MARKET  = 1'b1;

endpackage
`default_nettype wire

/* rtl/obm_cell.sv */
// One book entry cell: holds an entry and folds it into the search word passed down the row.
`default_nettype none
module obm_cell #(
	parameter int BOOK_DEPTH = 32,
	parameter int CELL_INDEX = 0,
	parameter bit IS_BID     = 1'b1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [31:0]                   counter,
	input  wire obm_pkg::cmd_t                 cmd,
	input  wire logic [$clog2(BOOK_DEPTH)-1:0] cmd_idx,
	input  wire obm_pkg::token_t               tok_in,
	input  wire logic [$clog2(BOOK_DEPTH)-1:0] idx_in,
	input  wire logic [$clog2(BOOK_DEPTH)-1:0] free_idx_in,
	output obm_pkg::token_t                    tok_out,
	output logic [$clog2(BOOK_DEPTH)-1:0]      idx_out,
	output logic [$clog2(BOOK_DEPTH)-1:0]      free_idx_out
);
	import obm_pkg::*;

	localparam int IW = $clog2(BOOK_DEPTH);
	localparam logic [IW-1:0] MY_IDX = CELL_INDEX[IW-1:0];

	logic        valid_q;
	logic [31:0] price_q, qty_q, id_q, seq_q;
	logic        sel;
	logic [31:0] age;
	logic        better;
	token_t      tok_q;
	logic [IW-1:0] idx_q, free_idx_q;

	assign sel = (cmd_idx == MY_IDX);
	assign age = counter - seq_q;

	always_comb begin
		better = 1'b0;
		if (valid_q) begin
			if (!tok_in.found)
				better = 1'b1;
			else if (price_q != tok_in.price)
				better = IS_BID ? (price_q > tok_in.price) : (price_q < tok_in.price);
			else
				better = (age > tok_in.age);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			case (cmd.op)
				CMD_REDUCE: if (qty_q == cmd.amount) valid_q <= 1'b0;
				CMD_LOAD:   valid_q <= 1'b1;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			case (cmd.op)
				CMD_REDUCE: qty_q <= qty_q - cmd.amount;
				CMD_LOAD: begin
					qty_q   <= cmd.amount;
					price_q <= cmd.price;
					id_q    <= cmd.id;
					seq_q   <= cmd.seq;
				end
				default: ;
			endcase
		end
	end

	// Advance the search word one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q      <= '0;
			idx_q      <= '0;
			free_idx_q <= '0;
		end else begin
			if (better) begin
				tok_q.found <= 1'b1;
				tok_q.price <= price_q;
				tok_q.qty   <= qty_q;
				tok_q.id    <= id_q;
				tok_q.age   <= age;
				idx_q       <= MY_IDX;
			end else begin
				tok_q.found <= tok_in.found;
				tok_q.price <= tok_in.price;
				tok_q.qty   <= tok_in.qty;
				tok_q.id    <= tok_in.id;
				tok_q.age   <= tok_in.age;
				idx_q       <= idx_in;
			end
			if (!tok_in.free_found && !valid_q) begin
				tok_q.free_found <= 1'b1;
				free_idx_q       <= MY_IDX;
			end else begin
				tok_q.free_found <= tok_in.free_found;
				free_idx_q       <= free_idx_in;
			end
		end
	end

	assign tok_out      = tok_q;
	assign idx_out      = idx_q;
	assign free_idx_out = free_idx_q;

endmodule
`default_nettype wire

/* rtl/order_book_matcher_unit.sv */
// Top level of the order book matcher: two rows of entry cells and the matching sequencer.
// On each fill the search word crosses the row of BOOK_DEPTH cells one cell a cycle, then a
// decision step, held while the output register is full, issues the trade and the entry update.
// An order runs a search per fill and a final one for the completion word, plus output stall;
// one order at a time; the next order is taken in the cycle after the completion word is loaded.
// Reset clears the valid bits of both sides and the arrival counter: the book starts empty.
// Entry payload is not cleared; an entry is read only once it has been loaded.
`default_nettype none
module order_book_matcher_unit #(
	parameter int BOOK_DEPTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             order_valid,
	output logic                  order_stall,
	input  wire obm_pkg::order_t  order,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output obm_pkg::result_t      result
);
	import obm_pkg::*;

	localparam int IW = $clog2(BOOK_DEPTH);
	localparam int CW = $clog2(BOOK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = BOOK_DEPTH[CW-1:0];

	state_t      state_q, state_d;
	order_t      ord_q;
	logic [31:0] counter_q;
	logic [31:0] seq_q;
	logic [31:0] rem_q;
	logic [CW-1:0] fills_q;
	logic [CW-1:0] wait_q;

	logic        res_valid_q;
	result_t     res_q;
	result_t     res_d;

	// Search rows: index 0 is the empty word entering the first cell.
	token_t        bid_tok  [BOOK_DEPTH+1];
	logic [IW-1:0] bid_idx  [BOOK_DEPTH+1];
	logic [IW-1:0] bid_fidx [BOOK_DEPTH+1];
	token_t        ask_tok  [BOOK_DEPTH+1];
	logic [IW-1:0] ask_idx  [BOOK_DEPTH+1];
	logic [IW-1:0] ask_fidx [BOOK_DEPTH+1];

	cmd_t          bid_cmd, ask_cmd, cmd;
	logic [IW-1:0] cmd_idx;

	assign bid_tok[0]  = '0;
	assign bid_idx[0]  = '0;
	assign bid_fidx[0] = '0;
	assign ask_tok[0]  = '0;
	assign ask_idx[0]  = '0;
	assign ask_fidx[0] = '0;

	for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cells
		obm_cell #(.BOOK_DEPTH(BOOK_DEPTH), .CELL_INDEX(i), .IS_BID(1'b1)) u_bid (
			.clk, .arst_n, .counter(counter_q), .cmd(bid_cmd), .cmd_idx,
			.tok_in(bid_tok[i]), .idx_in(bid_idx[i]), .free_idx_in(bid_fidx[i]),
			.tok_out(bid_tok[i+1]), .idx_out(bid_idx[i+1]), .free_idx_out(bid_fidx[i+1])
		);
		obm_cell #(.BOOK_DEPTH(BOOK_DEPTH), .CELL_INDEX(i), .IS_BID(1'b0)) u_ask (
			.clk, .arst_n, .counter(counter_q), .cmd(ask_cmd), .cmd_idx,
			.tok_in(ask_tok[i]), .idx_in(ask_idx[i]), .free_idx_in(ask_fidx[i]),
			.tok_out(ask_tok[i+1]), .idx_out(ask_idx[i+1]), .free_idx_out(ask_fidx[i+1])
		);
	end

	// Results of the finished search: best opposite entry, first free own entry.
	logic          sell, market;
	token_t        opp_tok, own_tok;
	logic [IW-1:0] opp_idx, own_fidx;
	logic          res_free, decide, price_ok, do_fill, do_rest;
	logic [31:0]   ex;

	assign sell     = (ord_q.order_side == SIDE_SELL);
	assign market   = (ord_q.order_kind == ORDER_MARKET);
	assign opp_tok  = sell ? bid_tok[BOOK_DEPTH] : ask_tok[BOOK_DEPTH];
	assign opp_idx  = sell ? bid_idx[BOOK_DEPTH] : ask_idx[BOOK_DEPTH];
	assign own_tok  = sell ? ask_tok[BOOK_DEPTH] : bid_tok[BOOK_DEPTH];
	assign own_fidx = sell ? ask_fidx[BOOK_DEPTH] : bid_fidx[BOOK_DEPTH];

	assign res_free = !res_valid_q || !result_stall;
	// The row is settled once the word has crossed every cell since the last change.
	assign decide   = (state_q == ST_SEARCH) && (wait_q == '0) && res_free;
	assign price_ok = market || (sell ? (opp_tok.price >= ord_q.limit_price)
	                                  : (opp_tok.price <= ord_q.limit_price));
	assign do_fill  = decide && (rem_q != '0) && (fills_q != DEPTH_C)
	                  && opp_tok.found && price_ok;
	assign do_rest  = decide && !do_fill && !market && (rem_q != '0) && own_tok.free_found;
	assign ex       = (rem_q < opp_tok.qty) ? rem_q : opp_tok.qty;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (order_valid) state_d = ST_SEARCH;
			ST_SEARCH: if (decide && !do_fill) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		order_stall = (state_q != ST_IDLE);
		cmd         = '0;
		cmd.op      = CMD_NONE;
		cmd_idx     = '0;
		if (do_fill) begin
			cmd.op     = CMD_REDUCE;
			cmd.amount = ex;
			cmd_idx    = opp_idx;
		end else if (do_rest) begin
			cmd.op     = CMD_LOAD;
			cmd.amount = rem_q;
			cmd.price  = ord_q.limit_price;
			cmd.id     = ord_q.order_id;
			cmd.seq    = seq_q;
			cmd_idx    = own_fidx;
		end
		// Route a fill to the opposite side, a rest to the order's own side.
		bid_cmd = cmd;
		ask_cmd = cmd;
		if (do_fill ? sell : !sell)
			ask_cmd.op = CMD_NONE;
		else
			bid_cmd.op = CMD_NONE;
	end

	// Build the next output word: a trade on a fill, otherwise the completion word.
	always_comb begin
		res_d = '0;
		if (do_fill) begin
			res_d.result_kind    = KIND_TRADE;
			res_d.buyer_id       = sell ? opp_tok.id : ord_q.order_id;
			res_d.seller_id      = sell ? ord_q.order_id : opp_tok.id;
			res_d.trade_price    = opp_tok.price;
			res_d.trade_quantity = ex;
			res_d.trade_time     = ord_q.arrival_time;
		end else begin
			res_d.result_kind       = KIND_COMPLETE;
			res_d.leftover_quantity = rem_q;
			res_d.did_rest          = do_rest;
			res_d.book_full         = !market && (rem_q != '0) && !own_tok.free_found;
			res_d.last_of_run       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			counter_q   <= '0;
			fills_q     <= '0;
			wait_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && order_valid) begin
				counter_q <= counter_q + 32'd1;
				fills_q   <= '0;
				wait_q    <= DEPTH_C;
			end else if (do_fill) begin
				fills_q <= fills_q + 1'b1;
				wait_q  <= DEPTH_C;
			end else if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
			// Hold a result until taken; load the next one only into a free register.
			if (decide)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && order_valid) begin
			ord_q <= order;
			seq_q <= counter_q;
			rem_q <= order.order_quantity;
		end else if (do_fill) begin
			rem_q <= rem_q - ex;
		end
		if (decide)
			res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

/* sim/order_book_matcher_checker.sv */
// Checker for the order book matcher: watches both channels, predicts results and compares.
`default_nettype none
module order_book_matcher_checker #(
	parameter int BOOK_DEPTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             order_valid,
	input  wire logic             order_stall,
	input  wire obm_pkg::order_t  order,
	input  wire logic             result_valid,
	input  wire logic             result_stall,
	input  wire obm_pkg::result_t result,
	output int                    fail_count,
	output int                    pending_count
);
	import obm_pkg::*;

	typedef struct {
		logic [31:0] price;
		logic [31:0] qty;
		logic [31:0] id;
		logic [31:0] seq;
		logic        live;
	} book_entry_t;

	book_entry_t bids[BOOK_DEPTH];
	book_entry_t asks[BOOK_DEPTH];
	logic [31:0] arrivals;
	result_t     awaited_results[$];

	function automatic int best_resting(input logic take_bids);
		int best;
		logic [31:0] bp, bage, p, age;
		logic better;
		book_entry_t e;
		best = -1;
		bp = '0;
		bage = '0;
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			e = take_bids ? bids[i] : asks[i];
			if (!e.live) continue;
			p = e.price;
			age = arrivals - e.seq;
			if (best < 0) better = 1'b1;
			else if (p != bp) better = take_bids ? (p > bp) : (p < bp);
			else better = age > bage;
			if (better) begin
				best = i;
				bp = p;
				bage = age;
			end
		end
		return best;
	endfunction

	task automatic match_order(input order_t o);
		logic sell, market, rested, full;
		logic [31:0] remaining, seq, rp, ex;
		int n, b, slot;
		result_t r;
		book_entry_t e;
		sell = (o.order_side == SIDE_SELL);
		market = (o.order_kind == ORDER_MARKET);
		remaining = o.order_quantity;
		seq = arrivals;
		arrivals = arrivals + 1;
		n = 0;
		rested = 0;
		full = 0;
		while (remaining != 0 && n < BOOK_DEPTH) begin
			b = best_resting(sell);
			if (b < 0) break;
			e = sell ? bids[b] : asks[b];
			rp = e.price;
			if (!market && (sell ? (rp < o.limit_price) : (rp > o.limit_price))) break;
			ex = (remaining < e.qty) ? remaining : e.qty;
			e.qty = e.qty - ex;
			if (e.qty == 0) e.live = 0;
			if (sell) bids[b] = e;
			else asks[b] = e;
			remaining = remaining - ex;
			r = '0;
			r.result_kind = KIND_TRADE;
			r.buyer_id = sell ? e.id : o.order_id;
			r.seller_id = sell ? o.order_id : e.id;
			r.trade_price = rp;
			r.trade_quantity = ex;
			r.trade_time = o.arrival_time;
			awaited_results = {awaited_results, r};
			n++;
		end
		if (!market && remaining != 0) begin
			slot = -1;
			for (int i = 0; i < BOOK_DEPTH; i++)
				if (slot < 0 && !(sell ? asks[i].live : bids[i].live)) slot = i;
			if (slot < 0) full = 1;
			else begin
				e.price = o.limit_price;
				e.qty = remaining;
				e.id = o.order_id;
				e.seq = seq;
				e.live = 1;
				if (sell) asks[slot] = e;
				else bids[slot] = e;
				rested = 1;
			end
		end
		r = '0;
		r.result_kind = KIND_COMPLETE;
		r.leftover_quantity = remaining;
		r.did_rest = rested;
		r.book_full = full;
		r.last_of_run = 1;
		awaited_results = {awaited_results, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < BOOK_DEPTH; i++) begin
				bids[i].live = 0;
				asks[i].live = 0;
			end
			arrivals = '0;
			awaited_results.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (result !== want) begin
						$display("%0t: result mismatch expected %p actual %p",
							$time, want, result);
						fail_count++;
					end
				end
			end
			if (order_valid && !order_stall) match_order(order);
			pending_count = awaited_results.size();
		end
	end
endmodule
`default_nettype wire

/* sim/tb_order_book_matcher_unit.sv */
// Testbench top for the order book matcher: stimulus, idling and verdict.
`default_nettype none
module tb_order_book_matcher_unit;
	import obm_pkg::*;

	localparam int BOOK_DEPTH = 32;
	localparam int SETTLE_CYCLES = 4 * (BOOK_DEPTH + 1);

	logic    clk;
	logic    arst_n;
	logic    order_valid;
	logic    order_stall;
	order_t  order;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	int      fail_count;
	int      pending_count;
	logic    calm;
	int      order_count;

	order_book_matcher_unit #(.BOOK_DEPTH(BOOK_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.order_valid(order_valid), .order_stall(order_stall), .order(order),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	order_book_matcher_checker #(.BOOK_DEPTH(BOOK_DEPTH)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.order_valid(order_valid), .order_stall(order_stall), .order(order),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Stall the result side in random bursts; hold off entirely once calm.
	initial begin
		int burst;
		result_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 13);
				result_stall <= 1;
				repeat (burst) @(posedge clk);
				result_stall <= 0;
			end
		end
	end

	// Present one word and hold it until it is taken; drop valid only when idling.
	task automatic send_order(input order_t o);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			order_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		order <= o;
		order_valid <= 1;
		do @(posedge clk); while (order_stall);
		order_count++;
	endtask

	function automatic order_t make_order(input logic side, input logic kind,
		input logic [31:0] price, input logic [31:0] qty);
		order_t o;
		o.order_side = side;
		o.order_kind = kind;
		o.order_id = $urandom;
		o.limit_price = price;
		o.order_quantity = qty;
		o.arrival_time = {$urandom, $urandom};
		return o;
	endfunction

	// Near-the-money prices so that orders cross often.
	function automatic order_t random_order();
		logic [31:0] price, qty;
		logic kind;
		price = 1000 + $urandom_range(0, 20) - 10;
		qty = $urandom_range(1, 40);
		kind = ($urandom_range(0, 5) == 0) ? ORDER_MARKET : ORDER_LIMIT;
		if ($urandom_range(0, 15) == 0) price = $urandom;
		if ($urandom_range(0, 15) == 0) qty = $urandom;
		return make_order($urandom_range(0, 1), kind, price, qty);
	endfunction

	initial begin
		order_t o;
		calm = 0;
		order_count = 0;
		arst_n = 0;
		order_valid = 0;
		order = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Market orders against an empty book, then zero quantity.
		send_order(make_order(SIDE_BUY, ORDER_MARKET, 32'd0, 32'd5));
		send_order(make_order(SIDE_SELL, ORDER_MARKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_order(make_order(SIDE_BUY, ORDER_LIMIT, 32'd100, 32'd0));
		// Equal prices: time priority and slot order, plus price extremes.
		send_order(make_order(SIDE_SELL, ORDER_LIMIT, 32'd100, 32'd10));
		send_order(make_order(SIDE_SELL, ORDER_LIMIT, 32'd100, 32'd20));
		send_order(make_order(SIDE_SELL, ORDER_LIMIT, 32'd90, 32'd5));
		send_order(make_order(SIDE_SELL, ORDER_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_order(make_order(SIDE_BUY, ORDER_LIMIT, 32'd0, 32'd7));
		send_order(make_order(SIDE_BUY, ORDER_LIMIT, 32'd100, 32'd30));
		send_order(make_order(SIDE_BUY, ORDER_MARKET, 32'd0, 32'hFFFF_FFFF));
		send_order(make_order(SIDE_SELL, ORDER_MARKET, 32'd0, 32'd3));
		// Fill the bid side, overflow it, then sweep it with one large sell.
		for (int i = 0; i < BOOK_DEPTH + 2; i++)
			send_order(make_order(SIDE_BUY, ORDER_LIMIT, 32'd50 + (i % 3), 32'd1 + (i % 4)));
		order_valid <= 0;
		wait (pending_count == 0);
		send_order(make_order(SIDE_SELL, ORDER_LIMIT, 32'd0, 32'hFFFF_FFFF));
		send_order(make_order(SIDE_SELL, ORDER_LIMIT, 32'd0, 32'hFFFF_FFFF));
		send_order(make_order(SIDE_SELL, ORDER_LIMIT, 32'd0, 32'hFFFF_FFFF));

		for (int n = 0; n < 60; n++) begin
			if (n == 45) calm = 1;
			send_order(random_order());
		end
		order_valid <= 0;

		wait (pending_count == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("order_book_matcher_unit verification clean");
		else
			$display("order_book_matcher_unit verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("order_book_matcher_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire
